// ----- rtl/gradient_centroid_subpixel_edge_macros.svh -----
// ----------------------------------------------------------------------------
// gradient_centroid_subpixel_edge_macros
// assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef GRADIENT_CENTROID_SUBPIXEL_EDGE_MACROS_SVH
`define GRADIENT_CENTROID_SUBPIXEL_EDGE_MACROS_SVH

// same-cycle implication, disabled in reset
`define GCSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gcse_pkg.sv -----
// ----------------------------------------------------------------------------
// gcse_pkg
// shared widths, tap indexes and pipeline sideband for the subpixel edge block
// ----------------------------------------------------------------------------
package gcse_pkg;

    localparam int GRAD_W = 9;
    localparam int TAPS   = 5;
    localparam int SUM_W  = 12;
    localparam int MAG_W  = 11;
    localparam int OUT_W  = 11;

    localparam int TAP_M2 = 0;
    localparam int TAP_M1 = 1;
    localparam int TAP_C  = 2;
    localparam int TAP_P1 = 3;
    localparam int TAP_P2 = 4;

    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic [TAPS-1:0][GRAD_W-1:0] grad_vec_t;

    typedef struct packed {
        logic vertical;
        logic dzero;
        logic neg;
        logic ovf;
    } gcse_side_t;

endpackage

// ----- rtl/gcse_front.sv -----
// ----------------------------------------------------------------------------
// gcse_front
// picks the axis and forms the weighted sums and their magnitudes
// ----------------------------------------------------------------------------
module gcse_front
    import gcse_pkg::*;
#(
    parameter int HALF_WINDOW = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  grad_vec_t          gx,
    input  grad_vec_t          gy,
    input  logic               adv_dn,
    output logic               adv,
    output logic               v,
    output logic [MAG_W-1:0]   an,
    output logic [MAG_W-1:0]   ad,
    output gcse_side_t         side
);

    localparam bit USE_OUTER = (HALF_WINDOW >= 2);

    logic                     v_reg;
    logic [MAG_W-1:0]         an_reg, an_next;
    logic [MAG_W-1:0]         ad_reg, ad_next;
    gcse_side_t               side_reg, side_next;

    logic signed [GRAD_W:0]   cx, cy;
    logic [GRAD_W:0]          agx, agy;
    logic                     vertical;
    logic signed [SUM_W-1:0]  ge [TAPS];
    logic signed [SUM_W-1:0]  num, den, num_abs, den_abs;

    assign adv = !v_reg || adv_dn;

    always_comb
    begin
        cx       = (GRAD_W+1)'(signed'(gx[TAP_C]));
        cy       = (GRAD_W+1)'(signed'(gy[TAP_C]));
        agx      = cx[GRAD_W] ? (GRAD_W+1)'(-cx) : (GRAD_W+1)'(cx);
        agy      = cy[GRAD_W] ? (GRAD_W+1)'(-cy) : (GRAD_W+1)'(cy);
        vertical = agy > agx;
        for (int i = 0; i < TAPS; i++)
        begin
            ge[i] = vertical ? SUM_W'(signed'(gy[i])) : SUM_W'(signed'(gx[i]));
        end
        num = ge[TAP_P1] - ge[TAP_M1];
        den = ge[TAP_M1] + ge[TAP_C] + ge[TAP_P1];
        if (USE_OUTER)
        begin
            num = num + ((ge[TAP_P2] - ge[TAP_M2]) <<< 1);
            den = den + ge[TAP_M2] + ge[TAP_P2];
        end
        num_abs = num[SUM_W-1] ? -num : num;
        den_abs = den[SUM_W-1] ? -den : den;
        an_next = num_abs[MAG_W-1:0];
        ad_next = den_abs[MAG_W-1:0];
        side_next.vertical = vertical;
        side_next.dzero    = (den == '0);
        side_next.neg      = num[SUM_W-1] ^ den[SUM_W-1];
        side_next.ovf      = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            an_reg   <= an_next;
            ad_reg   <= ad_next;
            side_reg <= side_next;
        end
    end

    assign v    = v_reg;
    assign an   = an_reg;
    assign ad   = ad_reg;
    assign side = side_reg;

endmodule

// ----- rtl/gcse_prep.sv -----
// ----------------------------------------------------------------------------
// gcse_prep
// builds the rounded dividend and divisor and flags quotient overflow
// ----------------------------------------------------------------------------
module gcse_prep
    import gcse_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            v_in,
    input  logic [MAG_W-1:0]                an,
    input  logic [MAG_W-1:0]                ad,
    input  gcse_side_t                      side_in,
    input  logic                            adv_dn,
    output logic                            adv,
    output logic                            v_out,
    output logic [MAG_W+FRAC_BITS+3:0]      rem_out,
    output logic [MAG_W:0]                  d_out,
    output gcse_side_t                      side_out
);

    localparam int QB = FRAC_BITS + 3;
    localparam int NW = MAG_W + FRAC_BITS + 4;

    logic              v_reg;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [MAG_W:0]    d_reg, d_next;
    gcse_side_t        side_reg, side_next;
    logic [NW-1:0]     d_top;

    assign adv = !v_reg || adv_dn;

    // dividend 2*an*2^F + ad over divisor 2*ad gives round half away from zero
    always_comb
    begin
        rem_next      = (NW'(an) << (FRAC_BITS + 1)) + NW'(ad);
        d_next        = {ad, 1'b0};
        d_top         = NW'(d_next) << QB;
        side_next     = side_in;
        side_next.ovf = (rem_next >= d_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            d_reg    <= d_next;
            side_reg <= side_next;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign d_out    = d_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/gcse_cell.sv -----
// ----------------------------------------------------------------------------
// gcse_cell
// one restoring division step, resolves one quotient bit
// ----------------------------------------------------------------------------
module gcse_cell
    import gcse_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int SHIFT     = 0
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            v_in,
    input  logic [MAG_W+FRAC_BITS+3:0]      rem_in,
    input  logic [MAG_W:0]                  d_in,
    input  logic [FRAC_BITS+2:0]            q_in,
    input  gcse_side_t                      side_in,
    input  logic                            adv_dn,
    output logic                            adv,
    output logic                            v_out,
    output logic [MAG_W+FRAC_BITS+3:0]      rem_out,
    output logic [MAG_W:0]                  d_out,
    output logic [FRAC_BITS+2:0]            q_out,
    output gcse_side_t                      side_out
);

    localparam int QB = FRAC_BITS + 3;
    localparam int NW = MAG_W + FRAC_BITS + 4;

    logic              v_reg;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [MAG_W:0]    d_reg;
    logic [QB-1:0]     q_reg, q_next;
    gcse_side_t        side_reg;
    logic [NW-1:0]     d_sh;
    logic              take;

    assign adv = !v_reg || adv_dn;

    always_comb
    begin
        d_sh     = NW'(d_in) << SHIFT;
        take     = (rem_in >= d_sh);
        rem_next = take ? (rem_in - d_sh) : rem_in;
        q_next   = q_in | (QB'(take) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            d_reg    <= d_in;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign d_out    = d_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/gcse_out.sv -----
// ----------------------------------------------------------------------------
// gcse_out
// saturates and signs the quotient and holds the result transaction
// ----------------------------------------------------------------------------
module gcse_out
    import gcse_pkg::*;
#(
    parameter int HALF_WINDOW = 2,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      v_in,
    input  logic [FRAC_BITS+2:0]      q_in,
    input  gcse_side_t                side_in,
    input  logic                      out_stall,
    output logic                      adv,
    output logic                      out_valid,
    output logic [OUT_W-1:0]          offset_x,
    output logic [OUT_W-1:0]          offset_y,
    output logic                      along_column,
    output logic                      valid_res
);

    localparam int QB = FRAC_BITS + 3;
    localparam int VW = (QB + 1 > OUT_W) ? QB + 1 : OUT_W;

    logic                 v_reg;
    logic [OUT_W-1:0]     offset_x_reg, offset_x_next;
    logic [OUT_W-1:0]     offset_y_reg, offset_y_next;
    logic                 along_column_reg;
    logic                 valid_res_reg, valid_res_next;

    logic [QB-1:0]        lim, one, mag;
    logic                 sat;
    logic signed [VW-1:0] mag_ext, sval;
    logic [OUT_W-1:0]     off;

    assign adv = !v_reg || !out_stall;

    always_comb
    begin
        lim     = QB'(HALF_WINDOW) << FRAC_BITS;
        one     = QB'(1) << FRAC_BITS;
        sat     = side_in.ovf || (q_in > lim);
        mag     = sat ? lim : q_in;
        mag_ext = signed'(VW'(mag));
        sval    = side_in.neg ? -mag_ext : mag_ext;
        off     = side_in.dzero ? '0 : sval[OUT_W-1:0];
        offset_x_next  = side_in.vertical ? '0 : off;
        offset_y_next  = side_in.vertical ? off : '0;
        valid_res_next = !side_in.dzero && !sat && (mag < one);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            offset_x_reg     <= offset_x_next;
            offset_y_reg     <= offset_y_next;
            along_column_reg <= side_in.vertical;
            valid_res_reg    <= valid_res_next;
        end
    end

    assign out_valid    = v_reg;
    assign offset_x     = offset_x_reg;
    assign offset_y     = offset_y_reg;
    assign along_column = along_column_reg;
    assign valid_res    = valid_res_reg;

endmodule

// ----- rtl/gradient_centroid_subpixel_edge.sv -----
// a transaction passes the registered front, prep, division cell and output stages in that order
// throughput: one transaction per cycle while out_stall is low; each stage moves when the next one is empty or moving
// the division is a chain of FRAC_BITS + 3 restoring cells, one quotient bit per cell
// reset clears every stage valid bit; payload registers are not reset
// ----------------------------------------------------------------------------
// gradient_centroid_subpixel_edge
// gradient-weighted centroid refinement of one edge pixel to subpixel offsets
// ----------------------------------------------------------------------------
module gradient_centroid_subpixel_edge
    import gcse_pkg::*;
#(
    parameter int HALF_WINDOW = 2,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [GRAD_W-1:0] row_gx_m2,
    input  logic signed [GRAD_W-1:0] row_gx_m1,
    input  logic signed [GRAD_W-1:0] row_gx_c,
    input  logic signed [GRAD_W-1:0] row_gx_p1,
    input  logic signed [GRAD_W-1:0] row_gx_p2,
    input  logic signed [GRAD_W-1:0] col_gy_m2,
    input  logic signed [GRAD_W-1:0] col_gy_m1,
    input  logic signed [GRAD_W-1:0] col_gy_c,
    input  logic signed [GRAD_W-1:0] col_gy_p1,
    input  logic signed [GRAD_W-1:0] col_gy_p2,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  offset_x,
    output logic signed [OUT_W-1:0]  offset_y,
    output logic                     along_column,
    output logic                     valid_res
);

    localparam int QB = FRAC_BITS + 3;
    localparam int NW = MAG_W + FRAC_BITS + 4;

    grad_vec_t          gx, gy;
    logic               front_adv, front_v;
    logic [MAG_W-1:0]   front_an, front_ad;
    gcse_side_t         front_side;

    // index 0 is the prep stage output, index j+1 the output of cell j
    logic               c_v    [QB+1];
    logic [NW-1:0]      c_rem  [QB+1];
    logic [MAG_W:0]     c_d    [QB+1];
    logic [QB-1:0]      c_q    [QB+1];
    gcse_side_t         c_side [QB+1];
    logic               c_adv  [QB+1];
    logic               out_adv;
    logic [OUT_W-1:0]   off_x, off_y;

    assign gx = {row_gx_p2, row_gx_p1, row_gx_c, row_gx_m1, row_gx_m2};
    assign gy = {col_gy_p2, col_gy_p1, col_gy_c, col_gy_m1, col_gy_m2};
    assign in_stall = !front_adv;

    gcse_front #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .gx       (gx),
        .gy       (gy),
        .adv_dn   (c_adv[0]),
        .adv      (front_adv),
        .v        (front_v),
        .an       (front_an),
        .ad       (front_ad),
        .side     (front_side)
    );

    gcse_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .v_in     (front_v),
        .an       (front_an),
        .ad       (front_ad),
        .side_in  (front_side),
        .adv_dn   (c_adv[1]),
        .adv      (c_adv[0]),
        .v_out    (c_v[0]),
        .rem_out  (c_rem[0]),
        .d_out    (c_d[0]),
        .side_out (c_side[0])
    );

    assign c_q[0] = '0;

    for (genvar j = 0; j < QB; j++)
    begin : g_cell
        logic adv_dn;

        assign adv_dn = (j == QB - 1) ? out_adv : c_adv[j+2 > QB ? QB : j+2];

        gcse_cell #(
            .FRAC_BITS (FRAC_BITS),
            .SHIFT     (QB - 1 - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .v_in     (c_v[j]),
            .rem_in   (c_rem[j]),
            .d_in     (c_d[j]),
            .q_in     (c_q[j]),
            .side_in  (c_side[j]),
            .adv_dn   (adv_dn),
            .adv      (c_adv[j+1]),
            .v_out    (c_v[j+1]),
            .rem_out  (c_rem[j+1]),
            .d_out    (c_d[j+1]),
            .q_out    (c_q[j+1]),
            .side_out (c_side[j+1])
        );
    end

    gcse_out #(
        .HALF_WINDOW (HALF_WINDOW),
        .FRAC_BITS   (FRAC_BITS)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .v_in         (c_v[QB]),
        .q_in         (c_q[QB]),
        .side_in      (c_side[QB]),
        .out_stall    (out_stall),
        .adv          (out_adv),
        .out_valid    (out_valid),
        .offset_x     (off_x),
        .offset_y     (off_y),
        .along_column (along_column),
        .valid_res    (valid_res)
    );

    assign offset_x = signed'(off_x);
    assign offset_y = signed'(off_y);

endmodule

// ----- rtl/gcse_checker.sv -----
// ----------------------------------------------------------------------------
// gcse_checker
// port-level checks on the result channel of the subpixel edge block
// ----------------------------------------------------------------------------
`include "gradient_centroid_subpixel_edge_macros.svh"

module gcse_checker
    import gcse_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [OUT_W-1:0]  offset_x,
    input logic signed [OUT_W-1:0]  offset_y,
    input logic                     along_column,
    input logic                     valid_res
);

    localparam int ONE = 1 << FRAC_BITS;

    `GCSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(offset_x) && $stable(offset_y) && $stable(valid_res),
        "stalled result transaction changed")

    `GCSE_ASSERT_NOW(a_column_x_zero, clk, rst_n, out_valid && along_column,
        offset_x == '0, "column result with nonzero x offset")

    `GCSE_ASSERT_NOW(a_row_y_zero, clk, rst_n, out_valid && !along_column,
        offset_y == '0, "row result with nonzero y offset")

    `GCSE_ASSERT_NOW(a_valid_subpixel, clk, rst_n, out_valid && valid_res,
        (int'(offset_x) < ONE) && (int'(offset_x) > -ONE) &&
        (int'(offset_y) < ONE) && (int'(offset_y) > -ONE),
        "valid result with offset of a pixel or more")

endmodule

bind gradient_centroid_subpixel_edge gcse_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);
